FILE: design/lpbp_pkg.sv
// Shared types and constants for the LRU page buffer policy block.
package lpbp_pkg;

    localparam int CMD_W   = 2;
    localparam int FILE_W  = 4;
    localparam int PAGE_W  = 32;
    localparam int SLOT_W  = 3;

    localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEW   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS  = CMD_W + FILE_W + PAGE_W + SLOT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = SLOT_W + 1 + 1 + FILE_W + PAGE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // register the incoming item
        logic single;      // execute a get, new or mark and load one result
        logic flush_step;  // process one slot of a flush and load its result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_flush;    // captured command is a flush
        logic out_free;    // output register can take a result this cycle
        logic flush_last;  // flush pointer sits on the highest slot
    } dp_sts_t;

endpackage

FILE: design/lru_page_buffer_policy_top.sv
// Top level of the LRU page buffer policy block: stream ports, controller and datapath.
//
// Channel   Direction  Contents
// s_axis    in         command requests: get, new, mark dirty, flush file
// m_axis    out        one result per get, new or mark; one result per slot for flush
//
// A get, new or mark item is first registered; then the tag compare across all
// slots, the LRU list update and the result load happen together. A flush is
// first registered; then the flush pointer walks the slots in order, loading one
// result per slot. Any cycle in which the output register is still full
// and not being taken holds the block where it is.
// Reset clears all valid and dirty marks and sets the LRU list to slot order;
// tags are not reset since an invalid slot never reports its tag.
module lru_page_buffer_policy_top
#(
    parameter int SLOTS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // s_axis_tdata: command[1:0], file_id[5:2], page_ref[37:6], slot_in[40:38], zero pad
    input  logic [lpbp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // m_axis_tdata: slot[2:0], hit[3], write_back[4], victim_file[8:5],
    // victim_page[40:9], zero pad
    output logic [lpbp_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import lpbp_pkg::*;

    ctrl_cmd_t         cmd;
    dp_sts_t           sts;
    logic [SLOT_W-1:0] res_slot;
    logic              res_hit;
    logic              res_wb;
    logic [FILE_W-1:0] res_vf;
    logic [PAGE_W-1:0] res_vp;

    // The controller sequences each item; the datapath holds all slot state.
    lpbp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpbp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_command      (s_axis_tdata[1:0]),
        .in_file_id      (s_axis_tdata[5:2]),
        .in_page_ref     (s_axis_tdata[37:6]),
        .in_slot         (s_axis_tdata[40:38]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_slot        (res_slot),
        .out_hit         (res_hit),
        .out_write_back  (res_wb),
        .out_victim_file (res_vf),
        .out_victim_page (res_vp),
        .out_last        (m_axis_tlast)
    );

    // Pack the result fields, lowest field first, zero padded to whole bytes.
    assign m_axis_tdata = OUT_W'({res_vp, res_vf, res_wb, res_hit, res_slot});

`ifndef NO_ASSERTIONS
    // A result is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.single || cmd.flush_step) |-> sts.out_free)
        else $error("result loaded into a full output register");

    // No result is produced while the block is open for a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(cmd.single || cmd.flush_step))
        else $error("result produced while idle");

    // After an item is taken the block works on it before taking another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted back to back");

    // The step for the highest slot ends the flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush_step && sts.flush_last) |=> s_axis_tready)
        else $error("flush did not end on the highest slot");
`endif

endmodule

FILE: design/lpbp_ctrl.sv
// Controller state machine for the LRU page buffer policy block.
module lpbp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpbp_pkg::dp_sts_t  sts,
    output lpbp_pkg::ctrl_cmd_t cmd
);
    import lpbp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.single     = 1'b0;
        cmd.flush_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    if (sts.is_flush)
                    begin
                        cmd.flush_step = 1'b1;
                        state_next     = sts.flush_last ? ST_IDLE : ST_FLUSH;
                    end
                    else
                    begin
                        cmd.single = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_step = 1'b1;
                    if (sts.flush_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/lpbp_datapath.sv
// Datapath of the LRU page buffer policy block: tags, marks, LRU list and output register.
module lpbp_datapath
#(
    parameter int SLOTS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lpbp_pkg::ctrl_cmd_t         cmd,
    output lpbp_pkg::dp_sts_t           sts,
    input  logic [lpbp_pkg::CMD_W-1:0]  in_command,
    input  logic [lpbp_pkg::FILE_W-1:0] in_file_id,
    input  logic [lpbp_pkg::PAGE_W-1:0] in_page_ref,
    input  logic [lpbp_pkg::SLOT_W-1:0] in_slot,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [lpbp_pkg::SLOT_W-1:0] out_slot,
    output logic                        out_hit,
    output logic                        out_write_back,
    output logic [lpbp_pkg::FILE_W-1:0] out_victim_file,
    output logic [lpbp_pkg::PAGE_W-1:0] out_victim_page,
    output logic                        out_last
);
    import lpbp_pkg::*;

    localparam int IDXW = $clog2(SLOTS);

    // Captured item.
    logic [CMD_W-1:0]  cmd_reg;
    logic [FILE_W-1:0] file_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [SLOT_W-1:0] sin_reg;

    // Slot state.
    logic [FILE_W-1:0] tag_file_reg [SLOTS];
    logic [PAGE_W-1:0] tag_page_reg [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  dirty_reg;
    logic [IDXW-1:0]   lru_reg [SLOTS];
    logic [IDXW-1:0]   lru_next [SLOTS];
    logic [IDXW-1:0]   cnt_reg;

    // Output register.
    logic              out_vld_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_hit_reg;
    logic              out_wb_reg;
    logic [FILE_W-1:0] out_vf_reg;
    logic [PAGE_W-1:0] out_vp_reg;
    logic              out_last_reg;

    logic [SLOTS-1:0]  match;
    logic              hit;
    logic [IDXW-1:0]   hit_idx;
    logic [IDXW-1:0]   victim;
    logic              is_get_hit;
    logic [IDXW-1:0]   sel_idx;
    logic [SLOTS-1:0]  pos_match;
    logic [SLOTS-1:0]  shift_en;
    logic              victim_wb;
    logic [IDXW-1:0]   mark_idx;
    logic              mark_ok;
    logic              flush_match;
    logic              flush_wb;
    logic              load;

    // Associative lookup, lowest matching slot wins.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = valid_reg[i] && (tag_file_reg[i] == file_reg)
                       && (tag_page_reg[i] == page_reg);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDXW'(i);
            end
        end
    end

    assign hit        = |match;
    assign victim     = lru_reg[0];
    assign is_get_hit = (cmd_reg == CMD_GET) && hit;
    assign sel_idx    = is_get_hit ? hit_idx : victim;
    assign victim_wb  = valid_reg[victim] && dirty_reg[victim];

    // Move the selected slot to the most recently used end.
    always_comb
    begin
        for (int p = 0; p < SLOTS; p++)
        begin
            pos_match[p] = (lru_reg[p] == sel_idx);
        end
        shift_en[0] = pos_match[0];
        for (int p = 1; p < SLOTS; p++)
        begin
            shift_en[p] = shift_en[p-1] | pos_match[p];
        end
        for (int p = 0; p < SLOTS - 1; p++)
        begin
            lru_next[p] = shift_en[p] ? lru_reg[p+1] : lru_reg[p];
        end
        lru_next[SLOTS-1] = sel_idx;
    end

    assign mark_idx    = IDXW'(sin_reg);
    assign mark_ok     = (32'(sin_reg) < 32'(SLOTS)) && valid_reg[mark_idx];
    assign flush_match = valid_reg[cnt_reg] && (tag_file_reg[cnt_reg] == file_reg);
    assign flush_wb    = flush_match && dirty_reg[cnt_reg];
    assign load        = cmd.single || cmd.flush_step;

    assign sts.is_flush   = (cmd_reg == CMD_FLUSH);
    assign sts.out_free   = !out_vld_reg || out_ready;
    assign sts.flush_last = (32'(cnt_reg) == 32'(SLOTS - 1));

    // Captured item, tags and result fields (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_command;
            file_reg <= in_file_id;
            page_reg <= in_page_ref;
            sin_reg  <= in_slot;
        end
        if (cmd.single && (cmd_reg != CMD_MARK) && !is_get_hit)
        begin
            tag_file_reg[victim] <= file_reg;
            tag_page_reg[victim] <= page_reg;
        end
        if (load)
        begin
            out_slot_reg <= '0;
            out_hit_reg  <= 1'b0;
            out_wb_reg   <= 1'b0;
            out_vf_reg   <= '0;
            out_vp_reg   <= '0;
            out_last_reg <= 1'b1;
            if (cmd.flush_step)
            begin
                out_slot_reg <= SLOT_W'(cnt_reg);
                out_wb_reg   <= flush_wb;
                out_last_reg <= sts.flush_last;
                if (flush_wb)
                begin
                    out_vf_reg <= tag_file_reg[cnt_reg];
                    out_vp_reg <= tag_page_reg[cnt_reg];
                end
            end
            else if (cmd_reg == CMD_MARK)
            begin
                out_slot_reg <= sin_reg;
            end
            else if (is_get_hit)
            begin
                out_slot_reg <= SLOT_W'(hit_idx);
                out_hit_reg  <= 1'b1;
            end
            else
            begin
                out_slot_reg <= SLOT_W'(victim);
                out_wb_reg   <= victim_wb;
                if (victim_wb)
                begin
                    out_vf_reg <= tag_file_reg[victim];
                    out_vp_reg <= tag_page_reg[victim];
                end
            end
        end
    end

    // Control state: marks, LRU list, flush pointer, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            dirty_reg   <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                lru_reg[i] <= IDXW'(i);
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            if (cmd.flush_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (flush_match)
                begin
                    valid_reg[cnt_reg] <= 1'b0;
                    dirty_reg[cnt_reg] <= 1'b0;
                end
            end
            if (cmd.single)
            begin
                if (cmd_reg == CMD_MARK)
                begin
                    if (mark_ok)
                    begin
                        dirty_reg[mark_idx] <= 1'b1;
                    end
                end
                else
                begin
                    if (!is_get_hit)
                    begin
                        valid_reg[victim] <= 1'b1;
                        dirty_reg[victim] <= 1'b0;
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        lru_reg[i] <= lru_next[i];
                    end
                end
            end
            if (load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_vld_reg;
    assign out_slot        = out_slot_reg;
    assign out_hit         = out_hit_reg;
    assign out_write_back  = out_wb_reg;
    assign out_victim_file = out_vf_reg;
    assign out_victim_page = out_vp_reg;
    assign out_last        = out_last_reg;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LRU page buffer policy block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lpbp_pkg::*;

    localparam int NUM_SLOTS     = 8;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 346;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              write_back;
        logic [FILE_W-1:0] victim_file;
        logic [PAGE_W-1:0] victim_page;
        logic              last;
    } page_result_t;

    // One row of the directed table. Rows with typed set carry the reply that
    // can be read straight off the buffer behavior; the others use the predictor.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot_in;
        bit                typed;
        page_result_t      reply;
    } request_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    lru_page_buffer_policy_top #(.SLOTS(NUM_SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the buffer state that the predictor keeps up to date.
    logic [FILE_W-1:0] shadow_file  [NUM_SLOTS];
    logic [PAGE_W-1:0] shadow_page  [NUM_SLOTS];
    logic              shadow_valid [NUM_SLOTS];
    logic              shadow_dirty [NUM_SLOTS];
    int                recency      [NUM_SLOTS];  // position 0 is least recently used

    // Replies owed by the block, oldest first.
    page_result_t page_results_due [$];

    // Traffic shaping knobs, in percent, and the long receiver hold-off request.
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_off_request;
    int  hold_off_cycles;

    int  mismatches;
    int  results_seen;
    int  hits_seen;
    int  write_backs_seen;
    int  command_count [4];

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Move a slot to the most recently used end of the recency list.
    task automatic promote_slot(input int s);
        int j;
        j = 0;
        while (j < NUM_SLOTS - 1 && recency[j] != s)
            j++;
        for (; j < NUM_SLOTS - 1; j++)
            recency[j] = recency[j + 1];
        recency[NUM_SLOTS - 1] = s;
    endtask

    // Retag the least recently used slot, reporting its page if it was dirty.
    task automatic evict_into(input logic [FILE_W-1:0] file, input logic [PAGE_W-1:0] page);
        page_result_t r;
        int           s;
        s = recency[0];
        r = '0;
        r.slot = SLOT_W'(s);
        r.last = 1'b1;
        if (shadow_valid[s] && shadow_dirty[s])
        begin
            r.write_back  = 1'b1;
            r.victim_file = shadow_file[s];
            r.victim_page = shadow_page[s];
        end
        shadow_file[s]  = file;
        shadow_page[s]  = page;
        shadow_valid[s] = 1'b1;
        shadow_dirty[s] = 1'b0;
        promote_slot(s);
        page_results_due.push_back(r);
    endtask

    // Work out the replies to one accepted request and update the shadow state.
    task automatic apply_buffer_command(input logic [CMD_W-1:0] cmd,
                                        input logic [FILE_W-1:0] file,
                                        input logic [PAGE_W-1:0] page,
                                        input logic [SLOT_W-1:0] slot_in);
        page_result_t r;
        int           found;
        found = -1;
        r = '0;
        case (cmd)
            CMD_GET:
            begin
                // A get matches the lowest numbered slot holding the tag.
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (shadow_valid[i] && shadow_file[i] == file && shadow_page[i] == page)
                        found = i;
                if (found >= 0)
                begin
                    promote_slot(found);
                    r.slot = SLOT_W'(found);
                    r.hit  = 1'b1;
                    r.last = 1'b1;
                    page_results_due.push_back(r);
                end
                else
                begin
                    evict_into(file, page);
                end
            end
            CMD_NEW:
            begin
                evict_into(file, page);
            end
            CMD_MARK:
            begin
                // Marking an empty slot leaves it alone but still answers.
                if (shadow_valid[slot_in])
                    shadow_dirty[slot_in] = 1'b1;
                r.slot = slot_in;
                r.last = 1'b1;
                page_results_due.push_back(r);
            end
            default:
            begin
                // Flush walks all slots in order and never touches the recency list.
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    r = '0;
                    r.slot = SLOT_W'(i);
                    r.last = (i == NUM_SLOTS - 1);
                    if (shadow_valid[i] && shadow_file[i] == file)
                    begin
                        if (shadow_dirty[i])
                        begin
                            r.write_back  = 1'b1;
                            r.victim_file = shadow_file[i];
                            r.victim_page = shadow_page[i];
                        end
                        shadow_valid[i] = 1'b0;
                        shadow_dirty[i] = 1'b0;
                    end
                    page_results_due.push_back(r);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the overall time limit.
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Far beyond the slowest legal run: every item a flush, every result stalled.
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side: offer one request and wait for the handshake.
    // ------------------------------------------------------------------

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FILE_W-1:0] file,
                                input logic [PAGE_W-1:0] page, input logic [SLOT_W-1:0] slot_in,
                                input bit typed, input page_result_t reply);
        logic [IN_W-1:0] word;
        // Random gaps before the item; each gap lasts one full cycle.
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        word = '0;
        word[CMD_W-1:0]                                = cmd;
        word[CMD_W +: FILE_W]                          = file;
        word[CMD_W + FILE_W +: PAGE_W]                 = page;
        word[CMD_W + FILE_W + PAGE_W +: SLOT_W]        = slot_in;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        // Handshake is judged on values from just before the rising edge.
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_buffer_command(cmd, file, page, slot_in);
        // Single-result rows may override the prediction with a hand-written reply.
        if (typed)
            page_results_due[page_results_due.size() - 1] = reply;
        command_count[cmd]++;
        @(negedge clk);
    endtask

    // Random request shaped to stay in a small working set so hits, dirty
    // evictions and flushes of live files happen often.
    task automatic send_random_request();
        logic [CMD_W-1:0]  cmd;
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot_in;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 45)
            cmd = CMD_GET;
        else if (roll < 65)
            cmd = CMD_NEW;
        else if (roll < 90)
            cmd = CMD_MARK;
        else
            cmd = CMD_FLUSH;
        file    = ($urandom_range(99) < 75) ? FILE_W'($urandom_range(3)) : FILE_W'($urandom());
        page    = ($urandom_range(99) < 75) ? PAGE_W'($urandom_range(7)) : PAGE_W'($urandom());
        slot_in = SLOT_W'($urandom());
        send_request(cmd, file, page, slot_in, 1'b0, '0);
    endtask

    function automatic page_result_t plain_reply(input int s, input logic hit);
        page_result_t r;
        r = '0;
        r.slot = SLOT_W'(s);
        r.hit  = hit;
        r.last = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: ready pattern, including one long hold-off.
    // ------------------------------------------------------------------

    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_left = hold_off_cycles;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        page_result_t seen;
        page_result_t want;
        bit           bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.slot        = m_axis_tdata[2:0];
            seen.hit         = m_axis_tdata[3];
            seen.write_back  = m_axis_tdata[4];
            seen.victim_file = m_axis_tdata[8:5];
            seen.victim_page = m_axis_tdata[40:9];
            seen.last        = m_axis_tlast;
            results_seen++;
            if (seen.hit)
                hits_seen++;
            if (seen.write_back)
                write_backs_seen++;
            if (page_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"[%0t] unexpected result: slot %0d hit %0b wb %0b",
                              " file %0d page %h last %0b"},
                             $realtime, seen.slot, seen.hit, seen.write_back,
                             seen.victim_file, seen.victim_page, seen.last);
            end
            else
            begin
                want = page_results_due.pop_front();
                bad = (seen.slot != want.slot) || (seen.hit != want.hit)
                   || (seen.write_back != want.write_back)
                   || (seen.victim_file != want.victim_file)
                   || (seen.victim_page != want.victim_page)
                   || (seen.last != want.last);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("[%0t] result mismatch #%0d", $realtime, mismatches);
                        $display("    expected: slot %0d hit %0b wb %0b file %0d page %h last %0b",
                                 want.slot, want.hit, want.write_back,
                                 want.victim_file, want.victim_page, want.last);
                        $display("    actual:   slot %0d hit %0b wb %0b file %0d page %h last %0b",
                                 seen.slot, seen.hit, seen.write_back,
                                 seen.victim_file, seen.victim_page, seen.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin
        request_row_t directed_rows [DIRECTED_ROWS];

        // Every input is known from time zero.
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_request   = 1'b0;
        hold_off_cycles    = 0;
        mismatches         = 0;
        results_seen       = 0;
        hits_seen          = 0;
        write_backs_seen   = 0;
        for (int c = 0; c < 4; c++)
            command_count[c] = 0;

        // Reset state of the shadow buffer: nothing valid, slots in index order.
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_file[i]  = '0;
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            recency[i]      = i;
        end

        // The first nine rows follow from the reset state by hand: a cold miss
        // lands in slot 0, a re-get hits, marking an empty slot is a no-op, and
        // a duplicate tag from a new command loses to the lower slot on a get.
        // Later rows fill the buffer, evict dirty pages and flush whole files.
        directed_rows = '{
            '{CMD_GET,   4'd0,  32'h0000_0000, 3'd0, 1'b1, plain_reply(0, 1'b0)},
            '{CMD_MARK,  4'd0,  32'h0000_0000, 3'd0, 1'b1, plain_reply(0, 1'b0)},
            '{CMD_GET,   4'd0,  32'h0000_0000, 3'd0, 1'b1, plain_reply(0, 1'b1)},
            '{CMD_NEW,   4'd15, 32'hFFFF_FFFF, 3'd7, 1'b1, plain_reply(1, 1'b0)},
            '{CMD_MARK,  4'd15, 32'hFFFF_FFFF, 3'd1, 1'b1, plain_reply(1, 1'b0)},
            '{CMD_MARK,  4'd0,  32'h0000_0000, 3'd7, 1'b1, plain_reply(7, 1'b0)},
            '{CMD_GET,   4'd15, 32'hFFFF_FFFF, 3'd0, 1'b1, plain_reply(1, 1'b1)},
            '{CMD_NEW,   4'd15, 32'hFFFF_FFFF, 3'd0, 1'b1, plain_reply(2, 1'b0)},
            '{CMD_GET,   4'd15, 32'hFFFF_FFFF, 3'd7, 1'b1, plain_reply(1, 1'b1)},
            '{CMD_FLUSH, 4'd3,  32'h1234_5678, 3'd5, 1'b0, '0},
            '{CMD_NEW,   4'd5,  32'hAAAA_AAAA, 3'd2, 1'b0, '0},
            '{CMD_NEW,   4'd5,  32'h5555_5555, 3'd5, 1'b0, '0},
            '{CMD_NEW,   4'd5,  32'h0000_0001, 3'd0, 1'b0, '0},
            '{CMD_MARK,  4'd5,  32'h0000_0000, 3'd4, 1'b0, '0},
            '{CMD_NEW,   4'd5,  32'h0000_0002, 3'd0, 1'b0, '0},
            '{CMD_NEW,   4'd5,  32'h0000_0003, 3'd0, 1'b0, '0},
            '{CMD_NEW,   4'd9,  32'h8000_0000, 3'd0, 1'b0, '0},
            '{CMD_GET,   4'd0,  32'h0000_0000, 3'd0, 1'b0, '0},
            '{CMD_FLUSH, 4'd15, 32'h0000_0000, 3'd0, 1'b0, '0},
            '{CMD_FLUSH, 4'd5,  32'hFFFF_FFFF, 3'd7, 1'b0, '0},
            '{CMD_GET,   4'd5,  32'h0000_0001, 3'd0, 1'b0, '0},
            '{CMD_MARK,  4'd0,  32'h0000_0000, 3'd0, 1'b0, '0},
            '{CMD_NEW,   4'd10, 32'h7FFF_FFFF, 3'd0, 1'b0, '0},
            '{CMD_GET,   4'd9,  32'h8000_0000, 3'd0, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].cmd, directed_rows[r].file, directed_rows[r].page,
                         directed_rows[r].slot_in, directed_rows[r].typed,
                         directed_rows[r].reply);

        // Random traffic in four idling phases: none, sender gaps, receiver
        // stalls, then light gaps on both sides. The random items are split
        // evenly, with the remainder going to the earliest phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 82;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 82;
                end
                default:
                begin
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4 + ((phase < RANDOM_ITEMS % 4) ? 1 : 0); n++)
            begin
                // One long receiver hold-off while requests keep coming, so the
                // output and input registers both fill and the input stalls.
                if (phase == 0 && n == 30)
                begin
                    hold_off_cycles  = 200;
                    hold_off_request = 1'b1;
                end
                send_random_request();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every owed reply, then a little longer for strays.
        while (page_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d get, %0d new, %0d mark, %0d flush.",
                 command_count[CMD_GET] + command_count[CMD_NEW] + command_count[CMD_MARK]
                 + command_count[CMD_FLUSH], command_count[CMD_GET], command_count[CMD_NEW],
                 command_count[CMD_MARK], command_count[CMD_FLUSH]);
        $display("Checked %0d results, %0d hits and %0d write-backs among them; %0d mismatches.",
                 results_seen, hits_seen, write_backs_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: lru_page_buffer_policy_top.f
design/lpbp_pkg.sv
design/lpbp_ctrl.sv
design/lpbp_datapath.sv
design/lru_page_buffer_policy_top.sv
tb/testbench.sv
